FILE: sv/encoder_angle_velocity_core_macros.svh
// Assertion helpers shared by the encoder angle and velocity block.
`ifndef ENCODER_ANGLE_VELOCITY_CORE_MACROS_SVH
`define ENCODER_ANGLE_VELOCITY_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EAV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EAV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/eav_pkg.sv
package eav_pkg;

	localparam int ANGLE_W = 12;
	localparam int MECH_W  = 13;
	localparam int DELTA_W = 14;
	localparam int POLE_W  = 6;
	localparam int US_W    = 16;
	localparam int VEL_W   = 32;
	localparam int PROD_W  = 58;
	localparam int QUO_W   = 31;
	localparam int CNT_W   = 5;

	// The velocity quotient is taken from the product shifted down by this many bits.
	localparam int SCALE_SHIFT = 20;
	// Lowest product bit that decides saturation before the division starts.
	localparam int SAT_LSB = QUO_W + SCALE_SHIFT;

	localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(ANGLE_W);
	localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUO_W);

	// round(pi * 2^24) times one million microseconds per second.
	localparam logic [PROD_W-1:0] VEL_SCALE = PROD_W'(64'd52707179000000);

	localparam logic signed [DELTA_W-1:0] HALF_REV = 14'sd2048;
	localparam logic signed [DELTA_W-1:0] FULL_REV = 14'sd4096;

	localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
	localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

	localparam logic [POLE_W-1:0] POLE_PAIRS_RST = 6'd7;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_PRIME  = 1'b1;

	localparam logic [1:0] REG_OFFSET  = 2'd0;
	localparam logic [1:0] REG_REVERSE = 2'd1;
	localparam logic [1:0] REG_POLES   = 2'd2;

	typedef struct packed {
		logic signed [MECH_W-1:0] mech;
		logic [ANGLE_W-1:0]       elec;
		logic [ANGLE_W-1:0]       mag;
		logic                     neg;
	} eav_angle_t;

endpackage

FILE: sv/eav_angle.sv
module eav_angle (
	input  logic [eav_pkg::ANGLE_W-1:0]        raw_angle,
	input  logic [eav_pkg::ANGLE_W-1:0]        angle_offset,
	input  logic                               reverse_direction,
	input  logic [eav_pkg::POLE_W-1:0]         pole_pairs,
	input  logic signed [eav_pkg::MECH_W-1:0]  last_mech,
	output eav_pkg::eav_angle_t                res
);
	import eav_pkg::*;

	logic signed [MECH_W-1:0]  mech;
	logic signed [18:0]        prod;
	logic [ANGLE_W-1:0]        prod_lo;
	logic signed [DELTA_W-1:0] delta;
	logic signed [DELTA_W-1:0] folded;
	logic [DELTA_W-1:0]        mag_full;

	always_comb begin
		mech    = $signed({1'b0, raw_angle}) - $signed({1'b0, angle_offset});
		prod    = mech * $signed({1'b0, pole_pairs});
		prod_lo = prod[ANGLE_W-1:0];

		delta = {mech[MECH_W-1], mech} - {last_mech[MECH_W-1], last_mech};
		// The delta is folded by one turn at most.
		if (delta > HALF_REV) begin
			folded = delta - FULL_REV;
		end else if (delta < -HALF_REV) begin
			folded = delta + FULL_REV;
		end else begin
			folded = delta;
		end
		mag_full = folded[DELTA_W-1] ? DELTA_W'(-folded) : DELTA_W'(folded);

		res.mech = mech;
		res.elec = reverse_direction ? (~prod_lo + ANGLE_W'(1)) : prod_lo;
		res.mag  = mag_full[ANGLE_W-1:0];
		res.neg  = !folded[DELTA_W-1] && (folded != '0);
	end

endmodule

FILE: sv/eav_alu.sv
module eav_alu (
	input  logic [eav_pkg::PROD_W-1:0] a,
	input  logic [eav_pkg::PROD_W-1:0] b,
	input  logic                       sub,
	output logic [eav_pkg::PROD_W-1:0] sum,
	output logic                       carry
);
	import eav_pkg::*;

	// On a subtract the carry out is high when a is not below b.
	assign {carry, sum} = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{PROD_W{1'b0}}, sub};

endmodule

FILE: sv/encoder_angle_velocity_core.sv
// A sample item runs 12 shift-add multiply steps, one saturation check and, unless the
// check saturates, 31 restoring divide steps, all on one shared 58-bit adder; a prime
// item, or a sample with zero elapsed time, goes straight to the output hand-over.
// A new item is taken only once the last one has been handed to the output register.
// Reset (arst_n low) clears the sequencer, the output valid, the stored last angle and
// the registers to offset 0, forward direction and 7 pole pairs.
`include "encoder_angle_velocity_core_macros.svh"

module encoder_angle_velocity_core (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [3:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               command,
	input  logic [eav_pkg::ANGLE_W-1:0]        raw_angle,
	input  logic [eav_pkg::US_W-1:0]           elapsed_us,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [eav_pkg::MECH_W-1:0]  mech_angle,
	output logic [eav_pkg::ANGLE_W-1:0]        elec_angle,
	output logic signed [eav_pkg::VEL_W-1:0]   velocity,
	output logic                               time_fault
);
	import eav_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHK,
		ST_DIV,
		ST_DONE
	} state_t;

	// Configuration registers.
	logic [ANGLE_W-1:0] angle_offset_q;
	logic               reverse_q;
	logic [POLE_W-1:0]  pole_pairs_q;

	// Sequencer and work registers.
	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [MECH_W-1:0] last_mech_q;
	logic signed [MECH_W-1:0] mech_q;
	logic [ANGLE_W-1:0]       elec_q;
	logic [ANGLE_W-1:0]       mag_q;
	logic                     neg_q;
	logic                     fault_q;
	logic [US_W-1:0]          us_q;
	logic [PROD_W-1:0]        acc_q;
	logic [US_W-1:0]          rem_q;
	logic [QUO_W-1:0]         quo_q;
	logic [VEL_W-1:0]         vel_q;

	// Output register.
	logic                     out_valid_q;
	logic signed [MECH_W-1:0] mech_out_q;
	logic [ANGLE_W-1:0]       elec_out_q;
	logic [VEL_W-1:0]         vel_out_q;
	logic                     fault_out_q;

	eav_angle_t        ang;
	logic [PROD_W-1:0] alu_a;
	logic [PROD_W-1:0] alu_b;
	logic              alu_sub;
	logic [PROD_W-1:0] alu_sum;
	logic              alu_ge;
	logic [QUO_W-1:0]  quo_next;
	logic              in_take;
	logic              cfg_wr;

	// The configuration port never waits. Register index is the word address.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_offset_q <= '0;
			reverse_q      <= 1'b0;
			pole_pairs_q   <= POLE_PAIRS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_OFFSET:  angle_offset_q <= pwdata[ANGLE_W-1:0];
				REG_REVERSE: reverse_q      <= pwdata[0];
				REG_POLES:   pole_pairs_q   <= pwdata[POLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_OFFSET:  prdata = 32'(angle_offset_q);
			REG_REVERSE: prdata = 32'(reverse_q);
			REG_POLES:   prdata = 32'(pole_pairs_q);
			default:     prdata = '0;
		endcase
	end

	// Angles and the folded delta are formed in the cycle the item is accepted.
	eav_angle u_angle (
		.raw_angle         (raw_angle),
		.angle_offset      (angle_offset_q),
		.reverse_direction (reverse_q),
		.pole_pairs        (pole_pairs_q),
		.last_mech         (last_mech_q),
		.res               (ang)
	);

	// The shared adder serves three jobs. While multiplying it adds the scale
	// constant into the doubled accumulator, one magnitude bit per cycle, MSB first.
	// In the check step it compares the product's top bits with the elapsed time:
	// not below means the quotient reaches 2^31 and the velocity saturates.
	// While dividing it trial-subtracts the elapsed time from the partial remainder.
	always_comb begin
		case (state_q)
			ST_MUL: begin
				alu_a   = {acc_q[PROD_W-2:0], 1'b0};
				alu_b   = mag_q[ANGLE_W-1] ? VEL_SCALE : '0;
				alu_sub = 1'b0;
			end
			ST_CHK: begin
				alu_a   = PROD_W'(acc_q[PROD_W-1:SAT_LSB]);
				alu_b   = PROD_W'(us_q);
				alu_sub = 1'b1;
			end
			ST_DIV: begin
				alu_a   = PROD_W'({rem_q, acc_q[SAT_LSB-1]});
				alu_b   = PROD_W'(us_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	eav_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.sum   (alu_sum),
		.carry (alu_ge)
	);

	assign quo_next = {quo_q[QUO_W-2:0], alu_ge};
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			last_mech_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						last_mech_q <= ang.mech;
						mech_q      <= ang.mech;
						elec_q      <= ang.elec;
						mag_q       <= ang.mag;
						neg_q       <= ang.neg;
						us_q        <= elapsed_us;
						fault_q     <= (command == CMD_SAMPLE) && (elapsed_us == '0);
						// A prime item, or a sample without elapsed time, has velocity zero.
						if ((command == CMD_SAMPLE) && (elapsed_us != '0)) begin
							acc_q   <= '0;
							cnt_q   <= MUL_STEPS - CNT_W'(1);
							state_q <= ST_MUL;
						end else begin
							vel_q   <= '0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL: begin
					acc_q <= alu_sum;
					mag_q <= {mag_q[ANGLE_W-2:0], 1'b0};
					if (cnt_q == '0) begin
						state_q <= ST_CHK;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_CHK: begin
					if (alu_ge) begin
						vel_q   <= neg_q ? VEL_MIN : VEL_MAX;
						state_q <= ST_DONE;
					end else begin
						rem_q   <= US_W'(acc_q[PROD_W-1:SAT_LSB]);
						quo_q   <= '0;
						cnt_q   <= DIV_STEPS - CNT_W'(1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= alu_ge ? alu_sum[US_W-1:0] : {rem_q[US_W-2:0], acc_q[SAT_LSB-1]};
					quo_q <= quo_next;
					acc_q <= {acc_q[PROD_W-2:0], 1'b0};
					if (cnt_q == '0) begin
						vel_q   <= neg_q ? (~{1'b0, quo_next} + VEL_W'(1)) : {1'b0, quo_next};
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DONE: begin
					// Hand over once the output register is free or being emptied.
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						mech_out_q  <= mech_q;
						elec_out_q  <= elec_q;
						vel_out_q   <= vel_q;
						fault_out_q <= fault_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign mech_angle = mech_out_q;
	assign elec_angle = elec_out_q;
	assign velocity   = vel_out_q;
	assign time_fault = fault_out_q;

	`EAV_ASSERT_IMP(a_rem_below_divisor, state_q == ST_DIV, rem_q < us_q, "remainder too large")
	`EAV_ASSERT_IMP(a_mul_count_range, state_q == ST_MUL, cnt_q < MUL_STEPS, "bad multiply count")
	`EAV_ASSERT_NXT(a_out_only_from_done, !out_valid_q && state_q != ST_DONE, !out_valid_q, "stray result")
	`EAV_ASSERT_IMP(a_fault_zero_velocity, out_valid_q && fault_out_q, vel_out_q == '0, "fault with velocity")

endmodule

FILE: test/encoder_angle_velocity_core_tb.sv
`timescale 1ns / 1ps

module encoder_angle_velocity_core_tb;
	import eav_pkg::*;

	// One revolution of the encoder and the velocity scaling, kept here on their own so that
	// the expected values do not lean on the block's internal constants.
	localparam int REV_COUNTS = 4096;
	localparam int HALF_TURN = REV_COUNTS / 2;
	localparam longint unsigned PI_Q24 = 64'd52707179;
	localparam longint unsigned US_PER_SEC = 64'd1000000;
	localparam longint unsigned COUNT_SCALE = 64'd1048576;
	localparam logic signed [31:0] VEL_SAT_HI = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VEL_SAT_LO = 32'sh8000_0000;

	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 215;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 60;

	// Row flags of the directed table.
	localparam bit NEW_CFG = 1'b1;
	localparam bit SAME_CFG = 1'b0;
	localparam bit TYPED = 1'b1;
	localparam bit MODEL = 1'b0;

	typedef struct packed {
		logic signed [MECH_W-1:0] mech;
		logic [ANGLE_W-1:0]       elec;
		logic signed [VEL_W-1:0]  vel;
		logic                     fault;
	} angle_result_t;

	typedef struct packed {
		bit                 load_cfg;
		logic [ANGLE_W-1:0] offset;
		logic               reverse;
		logic [POLE_W-1:0]  poles;
		logic               cmd;
		logic [ANGLE_W-1:0] raw;
		logic [US_W-1:0]    us;
		bit                 typed;
		angle_result_t      want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic command;
	logic [ANGLE_W-1:0] raw_angle;
	logic [US_W-1:0] elapsed_us;
	logic out_valid;
	logic out_stall;
	logic signed [MECH_W-1:0] mech_angle;
	logic [ANGLE_W-1:0] elec_angle;
	logic signed [VEL_W-1:0] velocity;
	logic time_fault;

	// Predictor copy of the registers and of the stored angle.
	logic [ANGLE_W-1:0] cfg_offset;
	logic cfg_reverse;
	logic [POLE_W-1:0] cfg_poles;
	int prev_mech;

	// Results that accepted items still owe, oldest first.
	angle_result_t pending_results[$];
	int mismatches;
	bit valid_high;
	bit quiet_tail;
	bit hold_request;

	encoder_angle_velocity_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.raw_angle (raw_angle),
		.elapsed_us(elapsed_us),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.mech_angle(mech_angle),
		.elec_angle(elec_angle),
		.velocity  (velocity),
		.time_fault(time_fault)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Computes the result of one item from the current settings and advances the stored
	// angle. The electrical angle is the low twelve bits of the signed product, which is the
	// same as the non-negative remainder modulo one turn.
	function automatic angle_result_t predict_angles(logic cmd, logic [ANGLE_W-1:0] raw,
			logic [US_W-1:0] us);
		angle_result_t r;
		int mech;
		int delta;
		longint prod;
		longint unsigned mag;
		longint unsigned quo;
		mech = int'(raw) - int'(cfg_offset);
		prod = longint'(mech) * longint'(cfg_poles);
		if (cfg_reverse) begin
			prod = -prod;
		end
		r.mech = mech[MECH_W-1:0];
		r.elec = prod[ANGLE_W-1:0];
		r.vel = '0;
		r.fault = 1'b0;
		if (cmd == CMD_SAMPLE) begin
			delta = mech - prev_mech;
			// The delta is folded once only; exactly half a turn stays as it is.
			if (delta > HALF_TURN) begin
				delta -= REV_COUNTS;
			end else if (delta < -HALF_TURN) begin
				delta += REV_COUNTS;
			end
			if (us == '0) begin
				r.fault = 1'b1;
			end else begin
				mag = longint'(delta < 0 ? -delta : delta);
				quo = (mag * PI_Q24 * US_PER_SEC) / (longint'(us) * COUNT_SCALE);
				// Velocity has the opposite sign of the delta and saturates to 32 bits.
				if (delta > 0) begin
					r.vel = (quo >= 64'h8000_0000) ? VEL_SAT_LO : -$signed(quo[31:0]);
				end else begin
					r.vel = (quo > 64'h7FFF_FFFF) ? VEL_SAT_HI : $signed(quo[31:0]);
				end
			end
		end
		prev_mech = mech;
		return r;
	endfunction

	function automatic stim_row_t dir_row(bit load_cfg, logic [ANGLE_W-1:0] offset,
			logic reverse, logic [POLE_W-1:0] poles, logic cmd, logic [ANGLE_W-1:0] raw,
			logic [US_W-1:0] us, bit typed, angle_result_t want);
		stim_row_t row;
		row.load_cfg = load_cfg;
		row.offset = offset;
		row.reverse = reverse;
		row.poles = poles;
		row.cmd = cmd;
		row.raw = raw;
		row.us = us;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	// Lowers valid if it is up and lets the block drain every owed result. Every item
	// gives one result, so an empty store means the block is idle.
	task automatic settle();
		if (valid_high) begin
			in_valid <= 1'b0;
			valid_high = 1'b0;
		end
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Setup cycle, access cycle, then the task waits with the bus released so that two writes
	// in a row never assign psel twice in one time step.
	task automatic write_reg(logic [1:0] reg_code, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_code, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config(logic [ANGLE_W-1:0] offset, logic reverse,
			logic [POLE_W-1:0] poles);
		settle();
		write_reg(REG_OFFSET, 32'(offset));
		write_reg(REG_REVERSE, 32'(reverse));
		write_reg(REG_POLES, 32'(poles));
		cfg_offset = offset;
		cfg_reverse = reverse;
		cfg_poles = poles;
	endtask

	// Offers one item and holds it until it is taken. A typed expectation replaces the
	// predicted one, but the predictor still runs so that its stored angle keeps up.
	task automatic offer(logic cmd, logic [ANGLE_W-1:0] raw, logic [US_W-1:0] us,
			bit typed, angle_result_t want);
		angle_result_t predicted;
		command <= cmd;
		raw_angle <= raw;
		elapsed_us <= us;
		if (!valid_high) begin
			in_valid <= 1'b1;
			valid_high = 1'b1;
		end
		do @(posedge clk); while (in_stall);
		predicted = predict_angles(cmd, raw, us);
		pending_results.push_back(typed ? want : predicted);
		// Random gaps on the sending side, none in the closing phase.
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			valid_high = 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		stim_row_t rows[$];
		int sel;
		int step_size;
		int p;
		int k;
		logic cmd;
		logic [ANGLE_W-1:0] raw;
		logic [US_W-1:0] us;
		logic [ANGLE_W-1:0] last_raw;

		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		command <= CMD_SAMPLE;
		raw_angle <= '0;
		elapsed_us <= '0;
		valid_high = 1'b0;
		quiet_tail = 1'b0;
		hold_request = 1'b0;
		mismatches = 0;
		cfg_offset = '0;
		cfg_reverse = 1'b0;
		cfg_poles = POLE_PAIRS_RST;
		prev_mech = 0;

		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings first: a prime at zero, a sample with zero elapsed time, the widest
		// readings, and a delta of exactly plus and minus half a turn at one microsecond,
		// which saturate the velocity in both directions.
		rows.push_back(dir_row(SAME_CFG, 12'd0, 1'b0, 6'd0, CMD_PRIME, 12'd0, 16'd0,
			TYPED, angle_result_t'{13'sd0, 12'd0, 32'sd0, 1'b0}));
		rows.push_back(dir_row(SAME_CFG, 12'd0, 1'b0, 6'd0, CMD_SAMPLE, 12'd0, 16'd0,
			TYPED, angle_result_t'{13'sd0, 12'd0, 32'sd0, 1'b1}));
		rows.push_back(dir_row(SAME_CFG, 12'd0, 1'b0, 6'd0, CMD_SAMPLE, 12'd4095, 16'd1,
			MODEL, '0));
		rows.push_back(dir_row(SAME_CFG, 12'd0, 1'b0, 6'd0, CMD_SAMPLE, 12'd2048, 16'd65535,
			MODEL, '0));
		rows.push_back(dir_row(SAME_CFG, 12'd0, 1'b0, 6'd0, CMD_SAMPLE, 12'd0, 16'd1,
			TYPED, angle_result_t'{13'sd0, 12'd0, VEL_SAT_HI, 1'b0}));
		rows.push_back(dir_row(SAME_CFG, 12'd0, 1'b0, 6'd0, CMD_SAMPLE, 12'd2048, 16'd1,
			TYPED, angle_result_t'{13'sd2048, 12'd2048, VEL_SAT_LO, 1'b0}));
		// Largest offset, reversed, 32 pole pairs: negative mechanical angles.
		rows.push_back(dir_row(NEW_CFG, 12'd4095, 1'b1, 6'd32, CMD_PRIME, 12'd0, 16'd65535,
			MODEL, '0));
		rows.push_back(dir_row(SAME_CFG, 12'd0, 1'b0, 6'd0, CMD_SAMPLE, 12'd4095, 16'd1000,
			MODEL, '0));
		rows.push_back(dir_row(SAME_CFG, 12'd0, 1'b0, 6'd0, CMD_SAMPLE, 12'd0, 16'd65535,
			MODEL, '0));
		// Deltas of nearly two turns either way, still larger than half a turn after one fold.
		rows.push_back(dir_row(NEW_CFG, 12'd0, 1'b0, 6'd1, CMD_SAMPLE, 12'd4095, 16'd500,
			MODEL, '0));
		rows.push_back(dir_row(NEW_CFG, 12'd4095, 1'b0, 6'd1, CMD_SAMPLE, 12'd0, 16'd500,
			MODEL, '0));
		// Zero pole pairs give a zero electrical angle; then all six pole bits set.
		rows.push_back(dir_row(NEW_CFG, 12'd0, 1'b0, 6'd0, CMD_PRIME, 12'd1234, 16'd300,
			TYPED, angle_result_t'{13'sd1234, 12'd0, 32'sd0, 1'b0}));
		rows.push_back(dir_row(NEW_CFG, 12'd0, 1'b1, 6'd63, CMD_SAMPLE, 12'd4095, 16'd2,
			MODEL, '0));
		rows.push_back(dir_row(SAME_CFG, 12'd0, 1'b0, 6'd0, CMD_SAMPLE, 12'd4095, 16'd0,
			MODEL, '0));
		rows.push_back(dir_row(SAME_CFG, 12'd0, 1'b0, 6'd0, CMD_SAMPLE, 12'd1, 16'd65535,
			MODEL, '0));
		rows.push_back(dir_row(NEW_CFG, 12'd2048, 1'b0, 6'd32, CMD_SAMPLE, 12'd0, 16'd1,
			MODEL, '0));

		foreach (rows[i]) begin
			if (rows[i].load_cfg) begin
				load_config(rows[i].offset, rows[i].reverse, rows[i].poles);
			end
			offer(rows[i].cmd, rows[i].raw, rows[i].us, rows[i].typed, rows[i].want);
		end
		last_raw = 12'd0;

		// Random phases, each under its own settings. The first two take the extremes of offset
		// and direction, with 32 and 1 pole pairs; the last one runs with no idling on either side.
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: load_config(12'd4095, 1'b1, 6'd32);
				1: load_config(12'd0, 1'b0, 6'd1);
				default: load_config(12'($urandom), 1'($urandom), 6'($urandom_range(1, 32)));
			endcase
			if (p == PHASES - 1) begin
				quiet_tail = 1'b1;
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// In the third phase the receiver holds off for a long stretch while items
				// keep coming, so the block backs up and stalls its input.
				if (p == 2 && k == 40) begin
					hold_request = 1'b1;
				end
				sel = $urandom_range(0, 99);
				// Most items follow a turning shaft: a sample a small step from the last
				// reading. Large steps, primes, zero times and pure noise are mixed in.
				if (sel < 10) begin
					cmd = CMD_PRIME;
					raw = 12'($urandom);
					us = 16'($urandom);
				end else if (sel < 25) begin
					cmd = 1'($urandom);
					raw = 12'($urandom);
					us = 16'($urandom);
				end else begin
					cmd = CMD_SAMPLE;
					if ($urandom_range(0, 9) == 0) begin
						step_size = int'($urandom_range(0, 4200)) - 2100;
					end else begin
						step_size = int'($urandom_range(0, 128)) - 64;
					end
					raw = 12'(int'(last_raw) + step_size);
					if (sel < 30) begin
						us = '0;
					end else if ($urandom_range(0, 3) == 0) begin
						us = 16'($urandom_range(1, 65535));
					end else begin
						us = 16'($urandom_range(50, 2000));
					end
				end
				offer(cmd, raw, us, MODEL, '0);
				last_raw = raw;
			end
		end

		// All stimulus is in; let the owed results arrive, then watch a while for strays.
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Output side: random stall bursts, one long hold-off on request, and no stalls in the
	// closing phase.
	initial begin : receiver
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				repeat ($urandom_range(0, 24)) @(posedge clk);
			end
		end
	end

	// Every result taken at an edge is compared with the oldest owed result.
	always @(posedge clk) begin : result_check
		angle_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no item owed: mech_angle %0d", mech_angle);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (mech_angle !== want.mech) begin
					$error("mech_angle expected %0d actual %0d", want.mech, mech_angle);
					mismatches++;
				end
				if (elec_angle !== want.elec) begin
					$error("elec_angle expected %0d actual %0d", want.elec, elec_angle);
					mismatches++;
				end
				if (velocity !== want.vel) begin
					$error("velocity expected %0d actual %0d", want.vel, velocity);
					mismatches++;
				end
				if (time_fault !== want.fault) begin
					$error("time_fault expected %0d actual %0d", want.fault, time_fault);
					mismatches++;
				end
			end
		end
	end

	// A hung handshake ends the run here.
	initial begin : watchdog
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/eav_pkg.sv
sv/eav_angle.sv
sv/eav_alu.sv
sv/encoder_angle_velocity_core.sv
test/encoder_angle_velocity_core_tb.sv
